// ===== hw/rtl/rcrc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rcrc_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int CFG_IDX_BITS   = 3;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_W = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_H = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_CELL_W   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_CELL_H   = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS   = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_INSET_X  = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_INSET_Y  = 3'd6;

	// register reset values
	localparam int RST_SCREEN_W = 320;
	localparam int RST_SCREEN_H = 240;
	localparam int RST_CELL_W   = 8;
	localparam int RST_CELL_H   = 16;
	localparam int RST_RADIUS   = 0;
	localparam int RST_INSET_X  = 0;
	localparam int RST_INSET_Y  = 0;

	// controller -> datapath
	typedef struct packed {
		logic row_ld;
		logic div_start;
		logic div_y;
		logic cols_ld;
		logic rows_ld;
		logic prep_ld;
		logic gap_ld;
		logic dysq_ld;
		logic dxsq_ld;
		logic step;
		logic res_zero;
		logic res_n;
		logic out_ld;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic degenerate;
		logic div_done;
		logic early_zero;
		logic py_clear;
		logic loop_end;
		logic arc_clear;
	} sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rcrc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module rcrc_div #(
	parameter int W = rcrc_pkg::COORD_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic      [W-1:0] quot,
	output logic              done
);
	localparam int CW = $clog2(W);

	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dsr_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    trial;
	logic [W:0]    diff;
	logic          ge;

	assign trial = {rem_q, quo_q[W-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CW'(1);
			if (cnt_q == CW'(W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[W-1:0] : trial[W-1:0];
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

	assign quot = quo_q;
	assign done = done_q;

endmodule
`default_nettype wire

// ===== hw/rtl/rcrc_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Config registers, divider, shared multiplier and arc walk registers.
module rcrc_dp #(
	parameter int W = rcrc_pkg::COORD_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [rcrc_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [W-1:0]                      cfg_data,
	input  wire logic [W-1:0]                      row_number,
	input  wire rcrc_pkg::cmd_t                    cmd,
	output rcrc_pkg::sts_t                         sts,
	output logic      [W-2:0]                      clipped_cells
);
	logic [W-1:0]   sw_q, sh_q, cw_q, ch_q, rad_q, ox_q, oy_q;
	logic [W-1:0]   row_q, cols_q, rows_q, rowch_q, rr_q, py_q;
	logic [2*W-1:0] rsq_q, dysq_q, dxsq_q;
	logic [W:0]     gx_q;
	logic [W-2:0]   n_q, res_q, out_q;

	logic [W:0]     twox, twoy, span_xw, span_yw;
	logic           span_bad, zero_cfg;
	logic [W-1:0]   m, rr, dy, dx;
	logic [W-1:0]   div_num, div_den, quot;
	logic           div_done;
	logic [W-1:0]   mul_a, mul_b;
	logic [2*W-1:0] prod;
	logic [W:0]     above, below, gap_y, py_w, px;
	logic [W-2:0]   half;
	logic [2*W:0]   sq_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q  <= W'(rcrc_pkg::RST_SCREEN_W);
			sh_q  <= W'(rcrc_pkg::RST_SCREEN_H);
			cw_q  <= W'(rcrc_pkg::RST_CELL_W);
			ch_q  <= W'(rcrc_pkg::RST_CELL_H);
			rad_q <= W'(rcrc_pkg::RST_RADIUS);
			ox_q  <= W'(rcrc_pkg::RST_INSET_X);
			oy_q  <= W'(rcrc_pkg::RST_INSET_Y);
		end else if (cfg_we) begin
			unique case (cfg_index)
				rcrc_pkg::REG_SCREEN_W: sw_q  <= cfg_data;
				rcrc_pkg::REG_SCREEN_H: sh_q  <= cfg_data;
				rcrc_pkg::REG_CELL_W:   cw_q  <= cfg_data;
				rcrc_pkg::REG_CELL_H:   ch_q  <= cfg_data;
				rcrc_pkg::REG_RADIUS:   rad_q <= cfg_data;
				rcrc_pkg::REG_INSET_X:  ox_q  <= cfg_data;
				rcrc_pkg::REG_INSET_Y:  oy_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// grid span; empty when twice the inset reaches the screen size
	assign twox     = {ox_q, 1'b0};
	assign twoy     = {oy_q, 1'b0};
	assign span_xw  = {1'b0, sw_q} - twox;
	assign span_yw  = {1'b0, sh_q} - twoy;
	assign span_bad = (twox >= {1'b0, sw_q}) || (twoy >= {1'b0, sh_q});
	assign zero_cfg = (sw_q == '0) || (sh_q == '0) || (cw_q == '0) || (ch_q == '0);

	// right/bottom margins are inset plus remainder, so the least margin is min(ox, oy)
	assign m  = (ox_q < oy_q) ? ox_q : oy_q;
	assign rr = rad_q - m;

	assign div_num = cmd.div_y ? span_yw[W-1:0] : span_xw[W-1:0];
	assign div_den = cmd.div_y ? ch_q : cw_q;

	rcrc_div #(.W(W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.quot     (quot),
		.done     (div_done)
	);

	// shared multiplier operand select
	always_comb begin
		if (cmd.prep_ld) begin
			mul_a = row_q;
			mul_b = ch_q;
		end else if (cmd.gap_ld) begin
			mul_a = rr_q;
			mul_b = rr_q;
		end else if (cmd.dysq_ld) begin
			mul_a = dy;
			mul_b = dy;
		end else begin
			mul_a = dx;
			mul_b = dx;
		end
	end
	assign prod = mul_a * mul_b;

	// vertical gap of this row; both sides stay non-negative for a row in the grid
	assign above = {1'b0, oy_q} + {1'b0, rowch_q};
	assign below = {1'b0, sh_q} - {1'b0, oy_q} - {1'b0, rowch_q} - {1'b0, ch_q};
	assign gap_y = (above < below) ? above : below;
	assign py_w  = gap_y - {1'b0, m};
	assign dy    = rr_q - py_q;

	// left gap never exceeds the right gap, so the walk uses the left one
	assign px     = gx_q - {1'b0, m};
	assign dx     = rr_q - px[W-1:0];
	assign half   = cols_q[W-1:1];
	assign sq_sum = {1'b0, dxsq_q} + {1'b0, dysq_q};

	always_ff @(posedge clk) begin
		if (cmd.row_ld)
			row_q <= row_number;
		if (cmd.cols_ld)
			cols_q <= quot;
		if (cmd.rows_ld)
			rows_q <= quot;
		if (cmd.prep_ld) begin
			rowch_q <= prod[W-1:0];
			rr_q    <= rr;
		end
		if (cmd.gap_ld) begin
			py_q  <= py_w[W-1:0];
			rsq_q <= prod;
			n_q   <= '0;
			gx_q  <= {1'b0, ox_q};
		end
		if (cmd.dysq_ld)
			dysq_q <= prod;
		if (cmd.dxsq_ld)
			dxsq_q <= prod;
		if (cmd.step) begin
			n_q  <= n_q + (W-1)'(1);
			gx_q <= gx_q + {1'b0, cw_q};
		end
		if (cmd.res_zero)
			res_q <= '0;
		else if (cmd.res_n)
			res_q <= n_q;
		if (cmd.out_ld)
			out_q <= res_q;
	end

	assign sts.degenerate = zero_cfg || span_bad;
	assign sts.div_done   = div_done;
	assign sts.early_zero = (cols_q == '0) || (row_q >= rows_q) || (rad_q <= m);
	assign sts.py_clear   = py_q >= rr_q;
	assign sts.loop_end   = (n_q >= half) || (px >= {1'b0, rr_q});
	assign sts.arc_clear  = sq_sum <= {1'b0, rsq_q};

	assign clipped_cells = out_q;

	// a result count never passes half the column count
	a_res_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_n |-> n_q <= half)
		else $error("cell count past half the columns");

	// a step happens only on a cell still inside the arc
	a_step_inside: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> !sts.loop_end && !sts.arc_clear)
		else $error("arc walk stepped past a clear cell");

endmodule
`default_nettype wire

// ===== hw/rtl/rcrc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Sequencer: divisions, setup products, arc walk, output hand-off.
module rcrc_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  wire logic           out_stall,
	input  wire rcrc_pkg::sts_t sts,
	output rcrc_pkg::cmd_t      cmd
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CHK  = 4'd1;
	localparam logic [3:0] S_DIVX = 4'd2;
	localparam logic [3:0] S_DIVY = 4'd3;
	localparam logic [3:0] S_CHK2 = 4'd4;
	localparam logic [3:0] S_GAP  = 4'd5;
	localparam logic [3:0] S_DY   = 4'd6;
	localparam logic [3:0] S_LSQ  = 4'd7;
	localparam logic [3:0] S_LCMP = 4'd8;
	localparam logic [3:0] S_FIN  = 4'd9;

	logic [3:0] state_q, state_d;
	logic       out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.row_ld = 1'b1;
					state_d    = S_CHK;
				end
			end
			S_CHK: begin
				if (sts.degenerate) begin
					cmd.res_zero = 1'b1;
					state_d      = S_FIN;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_DIVX;
				end
			end
			S_DIVX: begin
				if (sts.div_done) begin
					cmd.cols_ld   = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_y     = 1'b1;
					state_d       = S_DIVY;
				end
			end
			S_DIVY: begin
				if (sts.div_done) begin
					cmd.rows_ld = 1'b1;
					state_d     = S_CHK2;
				end
			end
			S_CHK2: begin
				if (sts.early_zero) begin
					cmd.res_zero = 1'b1;
					state_d      = S_FIN;
				end else begin
					cmd.prep_ld = 1'b1;
					state_d     = S_GAP;
				end
			end
			S_GAP: begin
				cmd.gap_ld = 1'b1;
				state_d    = S_DY;
			end
			S_DY: begin
				if (sts.py_clear) begin
					cmd.res_n = 1'b1;
					state_d   = S_FIN;
				end else begin
					cmd.dysq_ld = 1'b1;
					state_d     = S_LSQ;
				end
			end
			S_LSQ: begin
				if (sts.loop_end) begin
					cmd.res_n = 1'b1;
					state_d   = S_FIN;
				end else begin
					cmd.dxsq_ld = 1'b1;
					state_d     = S_LCMP;
				end
			end
			S_LCMP: begin
				if (sts.arc_clear) begin
					cmd.res_n = 1'b1;
					state_d   = S_FIN;
				end else begin
					cmd.step = 1'b1;
					state_d  = S_LSQ;
				end
			end
			S_FIN: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_ld)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	a_accept_chk: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == S_CHK)
		else $error("accepted item did not start");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_FIN))
		else $error("output valid raised outside finish");

	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> state_q == S_CHK || state_q == S_DIVX)
		else $error("divider started in wrong state");

endmodule
`default_nettype wire

// ===== hw/rtl/rounded_corner_row_clip.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Rounded-corner row clip.
// Give a grid row number on the input channel (in_valid / in_stall); the block
// answers on the output channel (out_valid / out_stall) with the number of cells
// at each end of that row that fall inside the display's corner arc.
// Geometry comes from seven registers written through cfg_valid / cfg_ready with
// cfg_index and cfg_data; cfg_ready is always high, unknown indexes are dropped.
// Write them only while no item is in flight.
// One item at a time: the input stalls from accept until the result moves into
// the output register. An item runs through two divisions on one restoring
// divider, checks and shared-multiplier setup, a walk across the cells that
// stops on the loop bound or on an arc compare, and the hand-off. A row whose
// first cell is already clear, a row past the grid, a radius inside the margin
// and bad geometry leave the sequence early.
// A finished result waits in the output register while out_stall is high; the
// next item is taken meanwhile and parks in the finish state if the output is
// still full. Reset loads the register defaults (320x240 screen, 8x16 cells,
// no radius, no inset) and empties the block.
module rounded_corner_row_clip #(
	parameter int COORD_BITS = rcrc_pkg::COORD_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [rcrc_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [COORD_BITS-1:0]             cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [COORD_BITS-1:0]             row_number,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic      [COORD_BITS-2:0]             clipped_cells
);
	rcrc_pkg::cmd_t cmd;
	rcrc_pkg::sts_t sts;

	// registers take a write on any cycle
	assign cfg_ready = 1'b1;

	rcrc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	rcrc_dp #(.W(COORD_BITS)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.row_number    (row_number),
		.cmd           (cmd),
		.sts           (sts),
		.clipped_cells (clipped_cells)
	);

endmodule
`default_nettype wire
